// ----- design/octn_pkg.sv -----
// ----------------------------------------------------------------------------
// octn_pkg
// Shared widths, register codes and word types of the octahedron projection.
// ----------------------------------------------------------------------------
`default_nettype none

package octn_pkg;

  localparam int COORD_WIDTH = 16;

  // configuration register fields
  localparam int CENTER_W  = 16;
  localparam int ROT_W     = 16;
  localparam int EXT_W     = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENTS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE   = 3'd5;

  localparam logic [CFG_W-1:0] CENTER_RESET  = 48'h0000_0000_0000;
  localparam logic [CFG_W-1:0] ROT0_RESET    = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] ROT1_RESET    = 48'h0000_4000_0000;
  localparam logic [CFG_W-1:0] ROT2_RESET    = 48'h4000_0000_0000;
  localparam logic [CFG_W-1:0] EXTENTS_RESET = 48'h0100_0100_0100;

  localparam int FRAC_ROT  = 14;
  localparam int FRAC_UNIT = 16;

  // reciprocal extents, Q8.16
  localparam int RECIP_W = 24;
  localparam logic [RECIP_W-1:0] RECIP_MAX   = 24'hFF_FFFF;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 24'h01_0000;
  localparam logic [4:0] RECIP_ONE_BIT = 5'd24;
  localparam int DEN_W = 50;
  localparam logic [DEN_W-1:0] DEN_RESET = 50'h3_0000_0000;

  // datapath widths
  localparam int DW  = ((COORD_WIDTH > CENTER_W) ? COORD_WIDTH : CENTER_W) + 1;
  localparam int PRW = DW + ROT_W;
  localparam int ACW = PRW + 2;
  localparam int LW  = DW + 4;
  localparam int ALW = LW + RECIP_W;
  localparam int SW  = ALW + 2;
  localparam int NMW = SW + 1;
  localparam int HIW = NMW - RECIP_W;
  localparam int XW  = NMW + RECIP_W;
  localparam int QW  = LW + 1;
  localparam int PW  = QW + 2;
  localparam int WPW = PW + ROT_W;
  localparam int WSW = WPW + 2;
  localparam int UPW = PW + RECIP_W + 1;
  localparam int RW  = PW + 10;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;
  } result_t;

  typedef struct packed {
    logic                         busy;
    logic [DEN_W-1:0]             den;
    logic [2:0][RECIP_W-1:0]      a;
  } recip_status_t;

  typedef struct packed {
    logic [2:0][LW-1:0] l;
    logic [2:0]         lpos;
    logic               nneg;
  } div_side_t;

endpackage

`default_nettype wire

// ----- design/octn_recip.sv -----
// ----------------------------------------------------------------------------
// octn_recip
// Reciprocal extents and their sum of squares, worked out after an extents
// write: one quotient bit a cycle per axis, then one square a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module octn_recip (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [octn_pkg::CFG_W-1:0]      ext,
  output octn_pkg::recip_status_t         status
);
  import octn_pkg::*;

  typedef enum logic [1:0] {IDLE, DIVIDE, SQUARE} state_t;

  state_t                  state;
  logic [1:0]              axis;
  logic [4:0]              bit_cnt;
  logic [EXT_W-1:0]        rem;
  logic [RECIP_W:0]        quo;
  logic [2:0][RECIP_W-1:0] a;
  logic [DEN_W-1:0]        den;

  logic [EXT_W-1:0]        e;
  logic [EXT_W:0]          trial;
  logic                    fits;
  logic [EXT_W-1:0]        rem_next;
  logic [RECIP_W:0]        quo_next;
  logic [RECIP_W-1:0]      recip;
  logic [2*RECIP_W-1:0]    sq;

  always_comb begin
    e        = ext[EXT_W*axis +: EXT_W];
    trial    = {rem, (bit_cnt == RECIP_ONE_BIT)};
    fits     = (trial >= {1'b0, e});
    rem_next = fits ? EXT_W'(trial - {1'b0, e}) : EXT_W'(trial);
    quo_next = {quo[RECIP_W-1:0], fits};
    // zero extent and one-lsb extent both end at the maximum
    if ((e == '0) || (quo_next > {1'b0, RECIP_MAX})) begin
      recip = RECIP_MAX;
    end else begin
      recip = quo_next[RECIP_W-1:0];
    end
    sq = a[axis] * a[axis];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      axis  <= '0;
      a     <= {RECIP_RESET, RECIP_RESET, RECIP_RESET};
      den   <= DEN_RESET;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            state   <= DIVIDE;
            axis    <= '0;
            bit_cnt <= RECIP_ONE_BIT;
            rem     <= '0;
            quo     <= '0;
          end
        end
        DIVIDE: begin
          if (bit_cnt == '0) begin
            a[axis] <= recip;
            rem     <= '0;
            quo     <= '0;
            bit_cnt <= RECIP_ONE_BIT;
            if (axis == 2'd2) begin
              state <= SQUARE;
              axis  <= '0;
              den   <= '0;
            end else begin
              axis <= axis + 2'd1;
            end
          end else begin
            rem     <= rem_next;
            quo     <= quo_next;
            bit_cnt <= bit_cnt - 5'd1;
          end
        end
        SQUARE: begin
          den <= den + DEN_W'(sq);
          if (axis == 2'd2) begin
            state <= IDLE;
            axis  <= '0;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign status.busy = (state != IDLE);
  assign status.den  = den;
  assign status.a    = a;

endmodule

`default_nettype wire

// ----- design/octn_div.sv -----
// ----------------------------------------------------------------------------
// octn_div
// Pipelined restoring divider, three lanes, one quotient bit per stage,
// rounding half up on the remainder at the end. Side data rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module octn_div (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic [2:0][octn_pkg::XW-1:0]                dividend,
  input  logic [octn_pkg::DEN_W-1:0]                  den,
  input  octn_pkg::div_side_t                         side_in,
  output logic                                        out_valid,
  output logic [2:0][octn_pkg::QW-1:0]                quot,
  output octn_pkg::div_side_t                         side_out
);
  import octn_pkg::*;

  logic [QW:0]             vld;
  logic [2:0][DEN_W-1:0]   rem  [QW+1];
  logic [2:0][QW-1:0]      low  [QW];
  logic [2:0][QW-1:0]      quo  [QW+1];
  div_side_t               side [QW+1];

  // quotient is known to fit QW bits, so the top of the dividend starts as remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= DEN_W'(dividend[k] >> QW);
        low[0][k] <= dividend[k][QW-1:0];
        quo[0][k] <= '0;
      end
      side[0] <= side_in;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [2:0][DEN_W-1:0] rem_n;
    logic [2:0]            qbit;

    always_comb begin
      logic [DEN_W:0] trial;
      for (int k = 0; k < 3; k++) begin
        trial    = {rem[s][k], low[s][k][QW-1]};
        qbit[k]  = (trial >= {1'b0, den});
        rem_n[k] = qbit[k] ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          rem[s+1][k] <= rem_n[k];
          quo[s+1][k] <= {quo[s][k][QW-2:0], qbit[k]};
        end
        side[s+1] <= side[s];
      end
    end

    // the last step has no dividend bits left to pass on
    if (s < QW - 1) begin : g_low
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            low[s+1][k] <= {low[s][k][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        quot[k] <= quo[QW][k] + QW'({rem[QW][k], 1'b0} >= {1'b0, den});
      end
      side_out <= side[QW];
    end
  end

endmodule

`default_nettype wire

// ----- design/octahedron_nearest_projection.sv -----
// ----------------------------------------------------------------------------
// octahedron_nearest_projection
// Projects a stream of points onto the surface of an oriented octahedron.
// ----------------------------------------------------------------------------
// Takes one point per cycle while in_ready is high and returns one word per
// point, in order; the one-bit-per-stage divider that scales the face offset
// is the deepest part of the pipeline. A stalled output stalls the whole
// pipeline. A write to the extents register starts the reciprocal unit,
// which divides for one axis after another and then sums three squares;
// in_ready stays low meanwhile. Other registers take effect at once; the user
// writes them only while no point is in flight, as the block does not enforce it.
`default_nettype none

module octahedron_nearest_projection (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  octn_pkg::point_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output octn_pkg::result_t                 out_data,
  input  logic                              cfg_we,
  input  logic [octn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [octn_pkg::CFG_W-1:0]        cfg_data
);
  import octn_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]      center_reg;
  logic [CFG_W-1:0]      rot_reg [3];
  logic [CFG_W-1:0]      ext_reg;
  logic                  space_reg;
  recip_status_t         rstatus;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_reg <= CENTER_RESET;
      rot_reg[0] <= ROT0_RESET;
      rot_reg[1] <= ROT1_RESET;
      rot_reg[2] <= ROT2_RESET;
      ext_reg    <= EXTENTS_RESET;
      space_reg  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER:  center_reg <= cfg_data;
        REG_ROT0:    rot_reg[0] <= cfg_data;
        REG_ROT1:    rot_reg[1] <= cfg_data;
        REG_ROT2:    rot_reg[2] <= cfg_data;
        REG_EXTENTS: ext_reg    <= cfg_data;
        REG_SPACE:   space_reg  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  octn_recip u_recip (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_we && (cfg_index == REG_EXTENTS)),
    .ext    (ext_reg),
    .status (rstatus)
  );

  logic signed [CENTER_W-1:0] c_s   [3];
  logic signed [ROT_W-1:0]    rot_s [3][3];
  logic signed [COORD_WIDTH-1:0] pin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_s[i] = signed'(center_reg[CENTER_W*i +: CENTER_W]);
      for (int j = 0; j < 3; j++) begin
        rot_s[i][j] = signed'(rot_reg[i][ROT_W*j +: ROT_W]);
      end
    end
    pin[0] = in_data.point_x;
    pin[1] = in_data.point_y;
    pin[2] = in_data.point_z;
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rstatus.busy;

  // valid bits of the stages outside the divider
  logic v1, v2, v3, v4, v5, v6, v7, vq, v9, v10, v11;

  // s1: difference to the center
  logic signed [DW-1:0] d [3];
  // s2: rotation products
  logic signed [PRW-1:0] prod [3][3];
  // s3: local coordinates
  logic signed [LW-1:0] l3 [3];
  // s4: |l| * a
  logic [ALW-1:0]       al [3];
  logic signed [LW-1:0] l4 [3];
  logic [2:0]           lpos4;
  // s5: numerator
  logic signed [SW:0]   num;
  logic signed [LW-1:0] l5 [3];
  logic [2:0]           lpos5;
  // s6: magnitude and sign of the numerator
  logic [NMW-1:0]       nabs;
  logic                 nneg6;
  logic signed [LW-1:0] l6 [3];
  logic [2:0]           lpos6;
  // s7: partial products of |num| * a
  logic [2*RECIP_W-1:0]     plo [3];
  logic [HIW+RECIP_W-1:0]   phi [3];
  div_side_t                side7;

  logic signed [ACW-1:0] acc_rot [3];
  logic [LW-1:0]         labs    [3];
  logic [SW-1:0]         s_sum;

  localparam logic signed [ACW-1:0] HALF_ROT  = ACW'(1) <<< (FRAC_ROT - 1);
  localparam logic [SW-1:0]         ONE_Q24   = SW'(1) << RECIP_W;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_rot[j] = ACW'(prod[0][j]) + ACW'(prod[1][j]) + ACW'(prod[2][j]) + HALF_ROT;
      labs[j]    = l3[j][LW-1] ? LW'(-l3[j]) : LW'(l3[j]);
    end
    s_sum = SW'(al[0]) + SW'(al[1]) + SW'(al[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else if (en) begin
      v1 <= in_valid && in_ready;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= DW'(pin[i]) - DW'(c_s[i]);
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= d[i] * rot_s[i][j];
        end
      end
      for (int j = 0; j < 3; j++) begin
        l3[j] <= LW'(acc_rot[j] >>> FRAC_ROT);
      end
      for (int j = 0; j < 3; j++) begin
        al[j]    <= ALW'(labs[j]) * ALW'(rstatus.a[j]);
        l4[j]    <= l3[j];
        // zero goes to the negative side
        lpos4[j] <= !l3[j][LW-1] && (l3[j] != '0);
      end
      num   <= signed'({1'b0, ONE_Q24}) - signed'({1'b0, s_sum});
      l5    <= l4;
      lpos5 <= lpos4;
      nneg6 <= num[SW];
      nabs  <= num[SW] ? NMW'(-num) : NMW'(num);
      l6    <= l5;
      lpos6 <= lpos5;
      for (int k = 0; k < 3; k++) begin
        plo[k] <= (2*RECIP_W)'(nabs[RECIP_W-1:0]) * (2*RECIP_W)'(rstatus.a[k]);
        phi[k] <= (HIW+RECIP_W)'(nabs[NMW-1:RECIP_W]) * (HIW+RECIP_W)'(rstatus.a[k]);
        side7.l[k] <= l6[k];
      end
      side7.lpos <= lpos6;
      side7.nneg <= nneg6;
    end
  end

  logic [2:0][XW-1:0] dividend;
  logic [2:0][QW-1:0] quot;
  div_side_t          side_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dividend[k] = (XW'(phi[k]) << RECIP_W) + XW'(plo[k]);
    end
  end

  octn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .dividend  (dividend),
    .den       (rstatus.den),
    .side_in   (side7),
    .out_valid (vq),
    .quot      (quot),
    .side_out  (side_q)
  );

  // s9: moved point, s10: products back out, s11: rounded result
  logic signed [PW-1:0]  lp    [3];
  logic signed [WPW-1:0] wprod [3][3];
  logic signed [UPW-1:0] uprod [3];
  logic signed [RW-1:0]  res   [3];

  logic signed [QW:0]    t     [3];
  logic signed [WSW-1:0] wsum  [3];
  logic signed [UPW-1:0] usum  [3];

  localparam logic signed [WSW-1:0] HALF_W = WSW'(1) <<< (FRAC_ROT - 1);
  localparam logic signed [UPW-1:0] HALF_U = UPW'(1) <<< (FRAC_UNIT - 1);
  localparam logic signed [RW-1:0]  OUT_MAX = RW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RW-1:0]  OUT_MIN = -OUT_MAX - RW'(1);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t[j]    = side_q.nneg ? -signed'({1'b0, quot[j]}) : signed'({1'b0, quot[j]});
      usum[j] = uprod[j] + HALF_U;
    end
    for (int i = 0; i < 3; i++) begin
      wsum[i] = WSW'(wprod[i][0]) + WSW'(wprod[i][1]) + WSW'(wprod[i][2]) + HALF_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v9, v10, v11, out_valid} <= '0;
    end else if (en) begin
      v9        <= vq;
      v10       <= v9;
      v11       <= v10;
      out_valid <= v11;
    end
  end

  logic signed [COORD_WIDTH-1:0] clamped [3];
  logic [2:0]                    clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (res[i] > OUT_MAX) begin
        clamped[i] = COORD_WIDTH'(OUT_MAX);
        clip[i]    = 1'b1;
      end else if (res[i] < OUT_MIN) begin
        clamped[i] = COORD_WIDTH'(OUT_MIN);
        clip[i]    = 1'b1;
      end else begin
        clamped[i] = COORD_WIDTH'(res[i]);
        clip[i]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        if (side_q.lpos[j]) begin
          lp[j] <= PW'(signed'(side_q.l[j])) + PW'(t[j]);
        end else begin
          lp[j] <= PW'(signed'(side_q.l[j])) - PW'(t[j]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          wprod[i][j] <= lp[j] * rot_s[i][j];
        end
        uprod[i] <= UPW'(lp[i]) * signed'(UPW'({1'b0, rstatus.a[i]}));
      end
      for (int i = 0; i < 3; i++) begin
        if (!space_reg) begin
          res[i] <= RW'(wsum[i] >>> FRAC_ROT) + RW'(c_s[i]);
        end else begin
          res[i] <= RW'(usum[i] >>> FRAC_UNIT);
        end
      end
      out_data.out_x     <= clamped[0];
      out_data.out_y     <= clamped[1];
      out_data.out_z     <= clamped[2];
      out_data.saturated <= |clip;
    end
  end

  // no point may enter while the reciprocals are being rebuilt
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    rstatus.busy |-> !in_ready)
    else $error("point accepted while reciprocal unit busy");

  a_ext_write_starts: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == REG_EXTENTS)) |=> rstatus.busy)
    else $error("extents write did not start reciprocal unit");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |->
      ((out_data.out_x == COORD_WIDTH'(OUT_MAX)) || (out_data.out_x == COORD_WIDTH'(OUT_MIN)) ||
       (out_data.out_y == COORD_WIDTH'(OUT_MAX)) || (out_data.out_y == COORD_WIDTH'(OUT_MIN)) ||
       (out_data.out_z == COORD_WIDTH'(OUT_MAX)) || (out_data.out_z == COORD_WIDTH'(OUT_MIN))))
    else $error("saturated word with no coordinate at a limit");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Streams points through the octahedron projection under several register
// settings and checks every word against a bit-exact software projection.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import octn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  point_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CENTER;
  logic [CFG_W-1:0] cfg_data = '0;

  octahedron_nearest_projection u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the block registers
  logic [CFG_W-1:0] sh_center = CENTER_RESET;
  logic [CFG_W-1:0] sh_rot [3] = '{ROT0_RESET, ROT1_RESET, ROT2_RESET};
  logic [CFG_W-1:0] sh_ext = EXTENTS_RESET;
  logic sh_space = 1'b0;

  point_t pending_points[$];
  result_t expected_proj[$];
  int mismatches = 0;
  bit idle_en = 1'b1;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint rnd_q(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic result_t project_point(point_t p);
    longint c[3], d[3], l[3], res[3], rot[3][3];
    longint num, s, acc, t, lim;
    longint unsigned a[3], den, e;
    logic [127:0] prod, q, r, un;
    logic signed [COORD_WIDTH-1:0] pc[3];
    bit flag;
    result_t o;
    pc[0] = p.point_x; pc[1] = p.point_y; pc[2] = p.point_z;
    s = 0; den = 0; flag = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed(sh_center[16*i +: 16]));
      d[i] = longint'(pc[i]) - c[i];
      for (int j = 0; j < 3; j++) rot[i][j] = longint'($signed(sh_rot[i][16*j +: 16]));
      e = sh_ext[16*i +: 16];
      if (e == 0) a[i] = RECIP_MAX;
      else begin
        a[i] = (64'd1 << 24) / e;
        if (a[i] > RECIP_MAX) a[i] = RECIP_MAX;
      end
      den += a[i] * a[i];
    end
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) acc += d[i] * rot[i][j];
      l[j] = rnd_q(acc, FRAC_ROT);
      s += ((l[j] < 0) ? -l[j] : l[j]) * longint'(a[j]);
    end
    num = (longint'(1) <<< 24) - s;
    for (int j = 0; j < 3; j++) begin
      un = (num < 0) ? 128'(-num) : 128'(num);
      prod = un * 128'(a[j]);
      q = prod / 128'(den);
      r = prod % 128'(den);
      if (r >= 128'(den) - r) q = q + 1;
      q = q & 128'h3FFF_FFFF_FFFF_FFFF;
      t = (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
      // a coordinate of zero goes to the negative side
      l[j] = (l[j] > 0) ? l[j] + t : l[j] - t;
    end
    for (int i = 0; i < 3; i++) begin
      if (!sh_space) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += l[j] * rot[i][j];
        res[i] = rnd_q(acc, FRAC_ROT) + c[i];
      end else begin
        res[i] = rnd_q(l[i] * longint'(a[i]), FRAC_UNIT);
      end
      lim = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      if (res[i] > lim) begin res[i] = lim; flag = 1; end
      if (res[i] < -lim - 1) begin res[i] = -lim - 1; flag = 1; end
    end
    o.out_x = res[0][COORD_WIDTH-1:0];
    o.out_y = res[1][COORD_WIDTH-1:0];
    o.out_z = res[2][COORD_WIDTH-1:0];
    o.saturated = flag;
    return o;
  endfunction

  // sender
  always @(posedge clk) begin
    bit taken;
    taken = in_valid && in_ready;
    if (taken) expected_proj.insert(expected_proj.size(), project_point(in_data));
    if (!in_valid || taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        in_data <= pending_points.pop_front();
        in_valid <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_proj.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        want = expected_proj.pop_front();
        if (want.out_x !== out_data.out_x || want.out_y !== out_data.out_y ||
            want.out_z !== out_data.out_z || want.saturated !== out_data.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
                     want.out_x, want.out_y, want.out_z, want.saturated,
                     out_data.out_x, out_data.out_y, out_data.out_z, out_data.saturated);
        end
      end
    end
    if (rst || hold_left > 0) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_en && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 13);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER:  sh_center = val;
      REG_ROT0:    sh_rot[0] = val;
      REG_ROT1:    sh_rot[1] = val;
      REG_ROT2:    sh_rot[2] = val;
      REG_EXTENTS: sh_ext = val;
      REG_SPACE:   sh_space = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained;
    do @(posedge clk);
    while (pending_points.size() != 0 || in_valid || expected_proj.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_rot_entry();
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd_extent();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      default: return 16'($urandom_range(16'h0040, 16'h1000));
    endcase
  endfunction

  task automatic random_settings();
    logic [CFG_W-1:0] v;
    for (int i = 0; i < 3; i++)
      v[16*i +: 16] = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 2048)) - 1024);
    write_reg(REG_CENTER, v);
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) v[16*j +: 16] = rnd_rot_entry();
      write_reg(REG_ROT0 + CFG_IDX_W'(k), v);
    end
    for (int i = 0; i < 3; i++) v[16*i +: 16] = rnd_extent();
    write_reg(REG_EXTENTS, v);
    write_reg(REG_SPACE, CFG_W'($urandom));
  endtask

  function automatic point_t rnd_point();
    point_t p;
    if ($urandom_range(0, 2) == 0) begin
      p = point_t'(48'({$urandom, $urandom}));
    end else begin
      p.point_x = $signed(sh_center[15:0]) + $signed(16'($urandom_range(0, 4096)) - 16'd2048);
      p.point_y = $signed(sh_center[31:16]) + $signed(16'($urandom_range(0, 4096)) - 16'd2048);
      p.point_z = $signed(sh_center[47:32]) + $signed(16'($urandom_range(0, 4096)) - 16'd2048);
    end
    return p;
  endfunction

  initial begin
    logic [15:0] edge_vals [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, directed points
    for (int i = 0; i < 6; i++)
      for (int k = 0; k < 3; k++)
        pending_points.insert(pending_points.size(),
          point_t'{edge_vals[i], edge_vals[(i + k) % 6], edge_vals[(i + 2*k) % 6]});
    pending_points.insert(pending_points.size(), point_t'{16'h0000, 16'h0000, 16'h0000});
    pending_points.insert(pending_points.size(), point_t'{16'h0080, 16'h0000, 16'hFF80});
    wait_drained();

    // unit mode with identity, plus an ignored register index
    write_reg(REG_SPACE, 48'h1);
    write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 6; i++)
      pending_points.insert(pending_points.size(),
        point_t'{edge_vals[i], edge_vals[5 - i], 16'h0000});
    wait_drained();

    // extreme extents and rotations
    write_reg(REG_CENTER, 48'h8000_7FFF_0000);
    write_reg(REG_ROT0, 48'h8000_7FFF_8000);
    write_reg(REG_ROT1, 48'h7FFF_8000_7FFF);
    write_reg(REG_ROT2, 48'h0000_0000_8000);
    write_reg(REG_EXTENTS, 48'h0000_0001_FFFF);
    write_reg(REG_SPACE, 48'h0);
    for (int i = 0; i < 4; i++)
      pending_points.insert(pending_points.size(),
        point_t'{edge_vals[i], edge_vals[i], edge_vals[i]});
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      random_settings();
      if (ph == 9) idle_en = 1'b0;
      for (int n = 0; n < 150; n++) pending_points.insert(pending_points.size(), rnd_point());
      if (ph == 3) hold_go = 1'b1;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
design/octn_pkg.sv
design/octn_recip.sv
design/octn_div.sv
design/octahedron_nearest_projection.sv
sim/tb_top.sv
